// ===== rtl/cell_std_dev_pooling_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for cell_std_dev_pooling_top
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CELL_STD_DEV_POOLING_TOP_ASSERT_SVH
`define CELL_STD_DEV_POOLING_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CSDP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("csdp check failed");
// next-cycle implication
`define CSDP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("csdp check failed");
`else
`define CSDP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSDP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/csdp_pkg.sv =====
// ----------------------------------------------------------------------------
// csdp_pkg
// Shared constants and types of the cell standard deviation pooling block.
// ----------------------------------------------------------------------------
package csdp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HALF  = 16;
    localparam int MAX_ROWS  = 1024;

    localparam int RESP_W   = 16;
    localparam int HREG_W   = 5;
    localparam int DREG_W   = 11;
    localparam int HALF_W   = $clog2(MAX_HALF + 1);
    localparam int SUB_W    = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
    localparam int DIM_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int EXT_W    = $clog2(2 * MAX_HALF + 1);
    localparam int AREA_W   = $clog2(4 * MAX_HALF * MAX_HALF + 1);
    localparam int ASQ_W    = 2 * AREA_W;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 27;
    localparam int SQS_W    = 42;
    localparam int WORD_W   = SUM_W + SQS_W;
    localparam int NUM_W    = AREA_W + SQS_W;
    localparam int ROOT_W   = (NUM_W + 1) / 2;
    localparam int CELL_W   = 20;
    localparam int DEV_W    = 16;

    localparam logic [1:0] REG_HALF_HEIGHT  = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    // effective (clamped) geometry
    typedef struct packed {
        logic [HALF_W-1:0] hh;
        logic [HALF_W-1:0] hw;
        logic [DIM_W-1:0]  w;
        logic [ROWS_W-1:0] h;
    } cfg_t;

    // completed cell handed to the arithmetic unit
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sqs;
        logic [EXT_W-1:0]        ch;
        logic [EXT_W-1:0]        cw;
        logic [CELL_W-1:0]       cell_idx;
        logic                    last;
    } emit_t;

endpackage

// ===== rtl/csdp_ram.sv =====
// ----------------------------------------------------------------------------
// csdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/csdp_accum.sv =====
// ----------------------------------------------------------------------------
// csdp_accum
// Raster counters and read-modify-write of the two accumulator banks.
// ----------------------------------------------------------------------------
module csdp_accum import csdp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     restart,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [RESP_W-1:0] first_response,
    input  logic signed [RESP_W-1:0] second_response,
    input  logic                     math_busy,
    output emit_t                    emit
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD0, S_RD1, S_WR1} state_t;

    state_t                   state_reg, state_next;
    logic [COL_W-1:0]         clr_reg, clr_next;
    logic [COL_W-1:0]         x_reg, x_next, qx_reg, qx_next, xbase_reg, xbase_next;
    logic [SUB_W-1:0]         rx_reg, rx_next, ry_reg, ry_next;
    logic [ROW_W-1:0]         y_reg, y_next, qy_reg, qy_next, ybase_reg, ybase_next;
    logic [CELL_W-1:0]        rowbase_reg, rowbase_next;
    logic signed [RESP_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic signed [31:0]       v_ext, v_prod;

    logic col_last, row_last, sub_x_last, sub_y_last, col_next_ok, row_next_ok, emit_hit;
    logic [DIM_W:0]  x_hi_sum, x_hi, x_lo;
    logic [ROWS_W:0] y_hi_sum, y_hi, y_lo;

    logic [COL_W-1:0]  raddr, waddr;
    logic [WORD_W-1:0] rdata [2];
    logic [WORD_W-1:0] wdata [2];
    logic [WORD_W-1:0] upd   [2];
    logic              we    [2];
    logic              row_ok[2];
    logic [SUM_W-1:0]  v_add;
    logic [SQS_W-1:0]  sq_add;

    assign col_last    = (DIM_W'(x_reg) + DIM_W'(1)) == cfg.w;
    assign row_last    = (ROWS_W'(y_reg) + ROWS_W'(1)) == cfg.h;
    assign sub_x_last  = (HALF_W'(rx_reg) + HALF_W'(1)) == cfg.hw;
    assign sub_y_last  = (HALF_W'(ry_reg) + HALF_W'(1)) == cfg.hh;
    assign x_hi_sum    = (DIM_W+1)'(xbase_reg) + (DIM_W+1)'(cfg.hw);
    assign y_hi_sum    = (ROWS_W+1)'(ybase_reg) + (ROWS_W+1)'(cfg.hh);
    assign col_next_ok = x_hi_sum < (DIM_W+1)'(cfg.w);
    assign row_next_ok = y_hi_sum < (ROWS_W+1)'(cfg.h);
    assign emit_hit    = (sub_y_last || row_last) && (sub_x_last || col_last);

    // cell extent clipped at the image edges
    assign x_hi = col_next_ok ? x_hi_sum : (DIM_W+1)'(cfg.w);
    assign y_hi = row_next_ok ? y_hi_sum : (ROWS_W+1)'(cfg.h);
    assign x_lo = ((DIM_W+1)'(xbase_reg) > (DIM_W+1)'(cfg.hw)) ?
                  (DIM_W+1)'(xbase_reg) - (DIM_W+1)'(cfg.hw) : '0;
    assign y_lo = ((ROWS_W+1)'(ybase_reg) > (ROWS_W+1)'(cfg.hh)) ?
                  (ROWS_W+1)'(ybase_reg) - (ROWS_W+1)'(cfg.hh) : '0;

    assign v_ext  = 32'(v_reg);
    assign v_prod = v_ext * v_ext;
    assign v_add  = SUM_W'(v_ext);
    assign sq_add = SQS_W'(sq_reg);

    assign raddr = (state_reg == S_RD1) ? qx_reg + COL_W'(1) : qx_reg;

    always_comb begin
        unique case (state_reg)
            S_CLEAR: waddr = clr_reg;
            S_RD1:   waddr = qx_reg;
            default: waddr = qx_reg + COL_W'(1);
        endcase
    end

    for (genvar b = 0; b < 2; b++) begin : g_bank
        assign upd[b] = {rdata[b][WORD_W-1:SUM_W] + sq_add, rdata[b][SUM_W-1:0] + v_add};
        assign row_ok[b] = (qy_reg[0] == b[0]) || row_next_ok;

        always_comb begin
            unique case (state_reg)
                S_CLEAR: begin
                    we[b]    = 1'b1;
                    wdata[b] = '0;
                end
                S_RD1: begin
                    we[b]    = row_ok[b];
                    // drop the emitted cell back to zero
                    wdata[b] = (emit_hit && qy_reg[0] == b[0]) ? '0 : upd[b];
                end
                S_WR1: begin
                    we[b]    = row_ok[b] && col_next_ok;
                    wdata[b] = upd[b];
                end
                default: begin
                    we[b]    = 1'b0;
                    wdata[b] = upd[b];
                end
            endcase
        end

        csdp_ram #(
            .WIDTH (WORD_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we[b]),
            .waddr (waddr),
            .wdata (wdata[b]),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

    always_comb begin
        emit.valid    = (state_reg == S_RD1) && emit_hit;
        emit.sum      = $signed(upd[qy_reg[0]][SUM_W-1:0]);
        emit.sqs      = upd[qy_reg[0]][WORD_W-1:SUM_W];
        emit.ch       = EXT_W'(y_hi - y_lo);
        emit.cw       = EXT_W'(x_hi - x_lo);
        emit.cell_idx = rowbase_reg + CELL_W'(qx_reg);
        emit.last     = !row_next_ok && !col_next_ok;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        x_next       = x_reg;
        rx_next      = rx_reg;
        qx_next      = qx_reg;
        xbase_next   = xbase_reg;
        y_next       = y_reg;
        ry_next      = ry_reg;
        qy_next      = qy_reg;
        ybase_next   = ybase_reg;
        rowbase_next = rowbase_reg;
        v_next       = v_reg;
        sq_next      = sq_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + COL_W'(1);
                if (clr_reg == COL_W'(MAX_WIDTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                v_next = (first_response > second_response) ? first_response
                                                            : second_response;
                if (s_tvalid) begin
                    state_next = S_RD0;
                end
            end
            S_RD0: begin
                sq_next = SQ_W'(v_prod);
                // hold until the arithmetic unit can take the cell
                if (!(emit_hit && math_busy)) begin
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                state_next = S_WR1;
            end
            S_WR1: begin
                state_next = S_IDLE;
                if (col_last) begin
                    x_next     = '0;
                    rx_next    = '0;
                    qx_next    = '0;
                    xbase_next = '0;
                    if (row_last) begin
                        y_next       = '0;
                        ry_next      = '0;
                        qy_next      = '0;
                        ybase_next   = '0;
                        rowbase_next = '0;
                    end else begin
                        y_next = y_reg + ROW_W'(1);
                        if (sub_y_last) begin
                            ry_next      = '0;
                            qy_next      = qy_reg + ROW_W'(1);
                            ybase_next   = ybase_reg + ROW_W'(cfg.hh);
                            rowbase_next = rowbase_reg + CELL_W'(qx_reg) + CELL_W'(1);
                        end else begin
                            ry_next = ry_reg + SUB_W'(1);
                        end
                    end
                end else begin
                    x_next = x_reg + COL_W'(1);
                    if (sub_x_last) begin
                        rx_next    = '0;
                        qx_next    = qx_reg + COL_W'(1);
                        xbase_next = xbase_reg + COL_W'(cfg.hw);
                    end else begin
                        rx_next = rx_reg + SUB_W'(1);
                    end
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (restart) begin
            state_next   = S_CLEAR;
            clr_next     = '0;
            x_next       = '0;
            rx_next      = '0;
            qx_next      = '0;
            xbase_next   = '0;
            y_next       = '0;
            ry_next      = '0;
            qy_next      = '0;
            ybase_next   = '0;
            rowbase_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            x_reg       <= '0;
            rx_reg      <= '0;
            qx_reg      <= '0;
            xbase_reg   <= '0;
            y_reg       <= '0;
            ry_reg      <= '0;
            qy_reg      <= '0;
            ybase_reg   <= '0;
            rowbase_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            x_reg       <= x_next;
            rx_reg      <= rx_next;
            qx_reg      <= qx_next;
            xbase_reg   <= xbase_next;
            y_reg       <= y_next;
            ry_reg      <= ry_next;
            qy_reg      <= qy_next;
            ybase_reg   <= ybase_next;
            rowbase_reg <= rowbase_next;
        end
        v_reg  <= v_next;
        sq_reg <= sq_next;
    end

endmodule

// ===== rtl/csdp_math.sv =====
// ----------------------------------------------------------------------------
// csdp_math
// Deviation of one cell: products, restoring divide, bit-pair square root.
// ----------------------------------------------------------------------------
module csdp_math import csdp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  emit_t             emit,
    output logic              busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CELL_W-1:0] cell_number,
    output logic [DEV_W-1:0]  deviation,
    output logic              frame_done
);

    typedef enum logic [2:0] {M_IDLE, M_AREA, M_PROD, M_DIFF, M_DIV, M_ROOT, M_OUT} state_t;

    localparam int STEP_W = $clog2(NUM_W);

    state_t                  state_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQS_W-1:0]        sqs_reg;
    logic [EXT_W-1:0]        ch_reg, cw_reg;
    logic [CELL_W-1:0]       cell_reg;
    logic                    last_reg;
    logic [AREA_W-1:0]       area_reg;
    logic [NUM_W-1:0]        aq_reg, ssq_reg;
    logic [ASQ_W-1:0]        asq_reg;
    logic [NUM_W-1:0]        q_reg;
    logic [ASQ_W-1:0]        rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [2*ROOT_W-1:0]     n_reg;
    logic [ROOT_W+1:0]       srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic                    valid_reg;
    logic [CELL_W-1:0]       out_cell_reg;
    logic [DEV_W-1:0]        out_dev_reg;
    logic                    out_last_reg;

    logic [SUM_W-1:0]   smag;
    logic [2*SUM_W-1:0] ssq_full;
    logic [NUM_W-1:0]   aq_full;
    logic [ASQ_W-1:0]   asq_full;
    logic [ASQ_W:0]     div_sh;
    logic               div_ge;
    logic [ASQ_W:0]     div_rem;
    logic [NUM_W-1:0]   q_next;
    logic [ROOT_W+1:0]  root_sh, root_trial;
    logic               root_ge;
    logic [ROOT_W-1:0]  root_next;
    logic               out_load;

    assign smag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign ssq_full = smag * smag;
    assign aq_full  = area_reg * sqs_reg;
    assign asq_full = area_reg * area_reg;

    assign div_sh  = {rem_reg, q_reg[NUM_W-1]};
    assign div_ge  = div_sh >= {1'b0, asq_reg};
    assign div_rem = div_ge ? div_sh - {1'b0, asq_reg} : div_sh;
    assign q_next  = {q_reg[NUM_W-2:0], div_ge};

    assign root_sh    = {srem_reg[ROOT_W-1:0], n_reg[2*ROOT_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign root_ge    = root_sh >= root_trial;
    assign root_next  = {root_reg[ROOT_W-2:0], root_ge};

    // load the output register once it is free or being drained
    assign out_load = (state_reg == M_OUT) && (!valid_reg || m_tready);

    assign busy        = (state_reg != M_IDLE);
    assign m_tvalid    = valid_reg;
    assign cell_number = out_cell_reg;
    assign deviation   = out_dev_reg;
    assign frame_done  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                M_IDLE: begin
                    if (emit.valid) begin
                        sum_reg   <= emit.sum;
                        sqs_reg   <= emit.sqs;
                        ch_reg    <= emit.ch;
                        cw_reg    <= emit.cw;
                        cell_reg  <= emit.cell_idx;
                        last_reg  <= emit.last;
                        state_reg <= M_AREA;
                    end
                end
                M_AREA: begin
                    area_reg  <= AREA_W'(ch_reg * cw_reg);
                    state_reg <= M_PROD;
                end
                M_PROD: begin
                    aq_reg    <= aq_full;
                    ssq_reg   <= NUM_W'(ssq_full);
                    asq_reg   <= asq_full;
                    state_reg <= M_DIFF;
                end
                M_DIFF: begin
                    // a negative variance counts as zero
                    q_reg     <= (aq_reg > ssq_reg) ? aq_reg - ssq_reg : '0;
                    rem_reg   <= '0;
                    step_reg  <= STEP_W'(NUM_W - 1);
                    state_reg <= M_DIV;
                end
                M_DIV: begin
                    q_reg   <= q_next;
                    rem_reg <= div_rem[ASQ_W-1:0];
                    if (step_reg == '0) begin
                        n_reg     <= (2*ROOT_W)'(q_next);
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_W - 1);
                        state_reg <= M_ROOT;
                    end else begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                M_ROOT: begin
                    n_reg    <= {n_reg[2*ROOT_W-3:0], 2'b00};
                    srem_reg <= root_ge ? root_sh - root_trial : root_sh;
                    root_reg <= root_next;
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= M_OUT;
                    end
                end
                M_OUT: begin
                    if (out_load) begin
                        out_cell_reg <= cell_reg;
                        out_last_reg <= last_reg;
                        out_dev_reg  <= (root_reg > ROOT_W'({DEV_W{1'b1}})) ?
                                        {DEV_W{1'b1}} : root_reg[DEV_W-1:0];
                        state_reg    <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/cell_std_dev_pooling_top.sv =====
// ----------------------------------------------------------------------------
// cell_std_dev_pooling_top
// Local standard deviation pooling of the larger of two filter responses.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the s_ stream, one transfer per pixel with
// both Q8.8 responses in s_tdata. Each pixel is added to up to four cell
// accumulators held in two RAM banks (even and odd cell rows). A pixel is
// accepted, then a read-modify-write sequence updates the cell at the current
// column and its right neighbor on both banks at once before the next is taken.
// When a pixel completes a cell, the cell goes to a shared arithmetic unit
// (products, 53-step restoring divide, 27-step square root): its result shows
// on the m_ stream from the output register. A pixel that completes a further
// cell while the unit is still busy waits for it.
// A finished result sits in the output register; while m_tready is low the
// unit holds its next result and, behind it, the input stalls.
// After reset and after every register write the block sweeps both banks to
// zero, with s_tready low. Registers sit on the APB port at byte addresses
// 0, 4, 8, 12; a write restarts the frame.
// ----------------------------------------------------------------------------
`include "cell_std_dev_pooling_top_assert.svh"

module cell_std_dev_pooling_top import csdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_response[15:0], second_response[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_number[19:0], deviation[35:20], zero
    output logic        m_tuser    // frame_done
);

    logic [HREG_W-1:0] half_height_reg, half_width_reg;
    logic [DREG_W-1:0] frame_width_reg, frame_height_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    cfg_t              cfg;
    emit_t             emit;
    logic              math_busy;
    logic [CELL_W-1:0] cell_number;
    logic [DEV_W-1:0]  deviation;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_height_reg  <= HREG_W'(3);
            half_width_reg   <= HREG_W'(3);
            frame_width_reg  <= DREG_W'(64);
            frame_height_reg <= DREG_W'(64);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HALF_HEIGHT:  half_height_reg  <= pwdata[HREG_W-1:0];
                REG_HALF_WIDTH:   half_width_reg   <= pwdata[HREG_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DREG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DREG_W-1:0];
                default:          half_height_reg  <= half_height_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HALF_HEIGHT:  prdata = 32'(half_height_reg);
            REG_HALF_WIDTH:   prdata = 32'(half_width_reg);
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp zero up to one and large values down to the supported maximum
    always_comb begin
        cfg.hh = (half_height_reg == '0) ? HALF_W'(1) :
                 (32'(half_height_reg) > MAX_HALF) ? HALF_W'(MAX_HALF) :
                 HALF_W'(half_height_reg);
        cfg.hw = (half_width_reg == '0) ? HALF_W'(1) :
                 (32'(half_width_reg) > MAX_HALF) ? HALF_W'(MAX_HALF) :
                 HALF_W'(half_width_reg);
        cfg.w  = (frame_width_reg == '0) ? DIM_W'(1) :
                 (32'(frame_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) :
                 DIM_W'(frame_width_reg);
        cfg.h  = (frame_height_reg == '0) ? ROWS_W'(1) :
                 (32'(frame_height_reg) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) :
                 ROWS_W'(frame_height_reg);
    end

    csdp_accum u_accum (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .restart         (cfg_wr),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .first_response  ($signed(s_tdata[15:0])),
        .second_response ($signed(s_tdata[31:16])),
        .math_busy       (math_busy),
        .emit            (emit)
    );

    csdp_math u_math (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .emit        (emit),
        .busy        (math_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cell_number (cell_number),
        .deviation   (deviation),
        .frame_done  (m_tuser)
    );

    assign m_tdata = {4'b0000, deviation, cell_number};

    `CSDP_ASSERT_NXT(a_write_starts_sweep, aclk, aresetn, cfg_wr, !s_tready)
    `CSDP_ASSERT_NXT(a_pixel_sequenced, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CSDP_ASSERT_IMP(a_math_free_on_emit, aclk, aresetn, emit.valid, !math_busy)

endmodule

// ===== test/cell_std_dev_pooling_top_test.sv =====
// ----------------------------------------------------------------------------
// cell_std_dev_pooling_top_test
// Streams pixels through the pooling block under several cell and frame
// geometries, predicts every completed cell's deviation and checks the results.
// ----------------------------------------------------------------------------
module cell_std_dev_pooling_top_test;
    import csdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct {
        logic [19:0] cell_idx;
        logic [15:0] dev;
        logic        last;
    } cell_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // first_response[15:0], second_response[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // cell_number[19:0], deviation[35:20], zero
    logic        m_tuser;        // frame_done

    cell_std_dev_pooling_top u_dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [4:0]      reg_hh = 5'd3, reg_hw = 5'd3;
    logic [10:0]     reg_w = 11'd64, reg_h = 11'd64;
    longint          cell_sum [2048];
    longint unsigned cell_sqsum [2048];
    int unsigned     col_pos, row_pos;

    logic [31:0]  pixel_q [$];
    cell_result_t cell_q [$];
    int  send_idle = 23, recv_idle = 65;
    bit  failed = 1'b0;
    bit  pixel_done;
    int  results_seen = 0;
    int  hold_cycles = 0;
    bit  hold_used = 1'b0;
    int  quiet_cycles = 0;

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void restart_frame();
        foreach (cell_sum[i]) begin
            cell_sum[i] = 0;
            cell_sqsum[i] = 0;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void queue_pixel(logic [31:0] px);
        pixel_q = {pixel_q, px};
    endfunction

    function automatic void pool_pixel(logic [31:0] px);
        int unsigned hh = clamp(reg_hh, MAX_HALF);
        int unsigned hw = clamp(reg_hw, MAX_HALF);
        int unsigned w = clamp(reg_w, MAX_WIDTH);
        int unsigned h = clamp(reg_h, MAX_ROWS);
        int unsigned nrows = (h + hh - 1) / hh;
        int unsigned ncols = (w + hw - 1) / hw;
        int unsigned x = col_pos, y = row_pos;
        logic signed [15:0] ra = px[15:0], rb = px[31:16];
        longint v = (ra > rb) ? ra : rb;
        longint unsigned sq = v * v;
        int unsigned cy, cx, yc, xc, y0, y1, x0, x1, idx;
        longint unsigned area, smag, ssq, aq, num, dev;
        cell_result_t r;
        for (int unsigned ky = y / hh; ky <= y / hh + 1 && ky < nrows; ky++)
            for (int unsigned kx = x / hw; kx <= x / hw + 1 && kx < ncols; kx++) begin
                idx = (ky & 1) * MAX_WIDTH + kx;
                cell_sum[idx] += v;
                cell_sqsum[idx] += sq;
            end
        if ((y + 1 == h || (y + 1) % hh == 0) && (x + 1 == w || (x + 1) % hw == 0)) begin
            cy = (y + 1 == h) ? nrows - 1 : (y + 1) / hh - 1;
            cx = (x + 1 == w) ? ncols - 1 : (x + 1) / hw - 1;
            yc = cy * hh;
            xc = cx * hw;
            y0 = (yc > hh) ? yc - hh : 0;
            y1 = (yc + hh < h) ? yc + hh : h;
            x0 = (xc > hw) ? xc - hw : 0;
            x1 = (xc + hw < w) ? xc + hw : w;
            area = longint'(y1 - y0) * longint'(x1 - x0);
            idx = (cy & 1) * MAX_WIDTH + cx;
            smag = (cell_sum[idx] < 0) ? -cell_sum[idx] : cell_sum[idx];
            ssq = smag * smag;
            aq = area * cell_sqsum[idx];
            num = (aq > ssq) ? aq - ssq : 0;
            dev = int_sqrt(num / (area * area));
            if (dev > 65535) dev = 65535;
            r.cell_idx = 20'(cy * ncols + cx);
            r.dev = dev[15:0];
            r.last = (cy == nrows - 1 && cx == ncols - 1);
            cell_q = {cell_q, r};
            cell_sum[idx] = 0;
            cell_sqsum[idx] = 0;
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    // input driver: advance after a transfer, else hold
    always @(negedge aclk) begin
        if (!s_tvalid || pixel_done) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off while pixels are still queued
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!hold_used && results_seen >= 60 && pixel_q.size() >= 40) begin
            hold_used <= 1'b1;
            hold_cycles <= 700;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cell_result_t e;
        pixel_done <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) pool_pixel(s_tdata);
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (cell_q.size() == 0) begin
                $error("unexpected result cell_number=%0d", m_tdata[19:0]);
                failed = 1'b1;
            end else begin
                e = cell_q.pop_front();
                if (m_tdata[19:0] !== e.cell_idx) begin
                    $error("cell_number expected %0d actual %0d", e.cell_idx, m_tdata[19:0]);
                    failed = 1'b1;
                end
                if (m_tdata[35:20] !== e.dev) begin
                    $error("deviation expected %0d actual %0d", e.dev, m_tdata[35:20]);
                    failed = 1'b1;
                end
                if (m_tuser !== e.last) begin
                    $error("frame_done expected %0d actual %0d", e.last, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("cell_std_dev_pooling_top_test: FAIL");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] index, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_HALF_HEIGHT:  reg_hh = value[4:0];
            REG_HALF_WIDTH:   reg_hw = value[4:0];
            REG_FRAME_WIDTH:  reg_w = value[10:0];
            REG_FRAME_HEIGHT: reg_h = value[10:0];
            default:          reg_hh = reg_hh;
        endcase
        restart_frame();
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !s_tvalid && cell_q.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_geometry(int hh, int hw, int w, int h);
        drain();
        apb_write(REG_HALF_HEIGHT, hh);
        apb_write(REG_HALF_WIDTH, hw);
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [15:0] random_response();
        case ($urandom_range(11))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int n;
        restart_frame();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // one pixel per cell: every transfer yields a result
        set_geometry(1, 1, 5, 5);
        queue_pixel({16'h8000, 16'h8000});
        queue_pixel({16'h7fff, 16'h7fff});
        queue_pixel({16'h8000, 16'h7fff});
        queue_pixel({16'h7fff, 16'h8000});
        queue_pixel({16'h0000, 16'hffff});
        queue_pixel({16'hffff, 16'h0000});
        queue_pixel({16'h0000, 16'h0000});
        queue_pixel({16'h1234, 16'h1234});
        for (int i = 0; i < 17; i++) queue_pixel({random_response(), random_response()});

        for (int p = 0; p < 9; p++) begin
            case (p)
                2: set_geometry(0, 31, 0, 2047);
                5: set_geometry(16, 16, 1100, 2);
                7: set_geometry(1, 2, 3, 1);
                default: set_geometry($urandom_range(4, 1), $urandom_range(4, 1),
                                      $urandom_range(16, 1), $urandom_range(10, 1));
            endcase
            send_idle = (p < 3) ? 23 : (p < 6) ? 65 : 0;
            recv_idle = (p < 3) ? 65 : (p < 6) ? 23 : 0;
            n = (p == 5) ? 100 : 80;
            for (int i = 0; i < n; i++) queue_pixel({random_response(), random_response()});
        end

        wait (pixel_q.size() == 0 && !s_tvalid && cell_q.size() == 0);
        repeat (150) @(posedge aclk);
        if (!failed && cell_q.size() == 0) begin
            $display("cell_std_dev_pooling_top_test: PASS");
        end else begin
            $display("cell_std_dev_pooling_top_test: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/csdp_pkg.sv
rtl/csdp_ram.sv
rtl/csdp_accum.sv
rtl/csdp_math.sv
rtl/cell_std_dev_pooling_top.sv
test/cell_std_dev_pooling_top_test.sv
